// ----- hw/rtl/fbg_pkg.sv -----
package fbg_pkg;

	// command codes carried in s_tuser
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	// status codes
	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_ZERO = 2'd2;
	localparam logic [1:0] STATUS_SAT  = 2'd3;

	localparam int ADDR_W       = 32;
	localparam int SIZE_W       = 16;   // block size in 512-byte units
	localparam int COUNT_W      = 16;   // block count - 1
	localparam int SIZE_SHIFT   = 9;    // 512 bytes per size unit
	localparam int BYTES_W      = SIZE_W + SIZE_SHIFT;
	localparam int REGION_IDX_W = 8;    // holds any region number up to 255
	localparam int QUO_W        = 16;
	localparam int DIVD_W       = ADDR_W - SIZE_SHIFT;
	localparam int RES_W        = 90;
	localparam int OUT_TDATA_W  = 96;
	localparam int IN_TDATA_W   = 64;

	// lookup request walking the cell chain
	typedef struct packed {
		logic                    active;
		logic                    hit;
		logic [REGION_IDX_W-1:0] region;
		logic [ADDR_W-1:0]       addr;
		logic [SIZE_W-1:0]       size;
	} token_t;

	// result word, lowest field declared last
	typedef struct packed {
		logic [1:0]  status;
		logic        boot_protected;
		logic [32:0] block_end;
		logic [31:0] block_start;
		logic [15:0] block_index;
		logic [4:0]  region_index;
		logic        found;
	} result_t;

endpackage

// ----- hw/rtl/fbg_cell.sv -----
module fbg_cell #(
	parameter int CAP_W = 33,
	parameter int IDX   = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fbg_pkg::token_t             tok_in,
	input  logic [CAP_W-1:0]            base_in,
	input  logic [CAP_W-1:0]            limit_in,
	input  logic                        live,
	input  logic                        wr_en,
	input  logic [CAP_W-1:0]            wr_base,
	input  logic [CAP_W-1:0]            wr_limit,
	input  logic [fbg_pkg::SIZE_W-1:0]  wr_size,
	output fbg_pkg::token_t             tok_out,
	output logic [CAP_W-1:0]            base_out,
	output logic [CAP_W-1:0]            limit_out
);
	import fbg_pkg::*;

	localparam int CMP_W = ((CAP_W > ADDR_W) ? CAP_W : ADDR_W) + 1;

	logic [CAP_W-1:0]  base_q;
	logic [CAP_W-1:0]  limit_q;
	logic [SIZE_W-1:0] size_q;
	logic [CMP_W-1:0]  addr_ext;
	logic              match;
	token_t            tok_q;
	logic [CAP_W-1:0]  tbase_q;
	logic [CAP_W-1:0]  tlimit_q;

	// region store of this cell
	always_ff @(posedge clk) begin
		if (wr_en) begin
			base_q  <= wr_base;
			limit_q <= wr_limit;
			size_q  <= wr_size;
		end
	end

	// first live, non-empty region covering the address wins
	assign addr_ext = CMP_W'(tok_in.addr);
	assign match = tok_in.active && !tok_in.hit && live && (size_q != '0)
		&& (addr_ext >= CMP_W'(base_q)) && (addr_ext < CMP_W'(limit_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.active <= tok_in.active;
			tok_q.hit    <= tok_in.hit | match;
			tok_q.addr   <= tok_in.addr;
			if (match) begin
				tok_q.region <= REGION_IDX_W'(IDX);
				tok_q.size   <= size_q;
			end else begin
				tok_q.region <= tok_in.region;
				tok_q.size   <= tok_in.size;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (match) begin
			tbase_q  <= base_q;
			tlimit_q <= limit_q;
		end else begin
			tbase_q  <= base_in;
			tlimit_q <= limit_in;
		end
	end

	assign tok_out   = tok_q;
	assign base_out  = tbase_q;
	assign limit_out = tlimit_q;

endmodule

// ----- hw/rtl/fbg_div.sv -----
module fbg_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fbg_pkg::DIVD_W-1:0] dividend,
	input  logic [fbg_pkg::SIZE_W-1:0] divisor,
	output logic                       done,
	output logic [fbg_pkg::QUO_W-1:0]  quotient
);
	import fbg_pkg::*;

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [SIZE_W-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [SIZE_W:0]   trial;
	logic              take;

	// restoring division, one quotient bit a cycle; quotient known to fit QUO_W bits
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign take  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(QUO_W);
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= SIZE_W'(dividend[DIVD_W-1:QUO_W]);
			quo_q <= dividend[QUO_W-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= take ? SIZE_W'(trial - {1'b0, divisor}) : trial[SIZE_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hw/rtl/flash_erase_block_geometry.sv -----
// Erase-block geometry table. Holds up to MAX_REGIONS erase-block regions laid end to end
// from address zero and answers one request at a time on the s_ stream, one result per
// request on the m_ stream. A clear request empties the table; an append request decodes
// one CFI region word (upper half = block size / 512, lower half = block count - 1) and
// places the region at the running end, saturating at 2^ADDRESS_BITS. A lookup request
// reports the first region covering the address, the block index in it and the block
// bounds, plus the boot-protect verdict (enabled and either table empty or address inside
// region 0's first block). The table lives in a chain of MAX_REGIONS cells; a lookup walks
// the chain one cell per cycle, then a divider produces the block index, and multiply and
// bound stages produce the block bounds.
// A new request is taken once the previous one has moved into the output register.
// boot_protect_enable is written on the cfg_ channel and resets to 1.
module flash_erase_block_geometry #(
	parameter int MAX_REGIONS  = 32,
	parameter int ADDRESS_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// config: boot_protect_enable
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [fbg_pkg::IN_TDATA_W-1:0]   s_tdata,  // address[31:0], descriptor[63:32]
	input  logic [1:0]                       s_tuser,  // command[1:0]
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [fbg_pkg::OUT_TDATA_W-1:0]  m_tdata   // found[0], region_index[5:1],
	                                                   // block_index[21:6],
	                                                   // block_start[53:22],
	                                                   // block_end[86:54],
	                                                   // boot_protected[87], status[89:88],
	                                                   // zero[95:90]
);
	import fbg_pkg::*;

	localparam int CAP_W   = ADDRESS_BITS + 1;
	localparam int CMP_W   = ((CAP_W > ADDR_W) ? CAP_W : ADDR_W) + 1;
	localparam int PROD_W  = BYTES_W + COUNT_W + 1;
	localparam int SUM_W   = ((CAP_W > PROD_W) ? CAP_W : PROD_W) + 1;
	localparam int SW      = CMP_W + 1;
	localparam int CNT_W   = $clog2(MAX_REGIONS + 1);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_APPEND = 7'b0000010,
		ST_SCAN   = 7'b0000100,
		ST_DIV    = 7'b0001000,
		ST_MUL    = 7'b0010000,
		ST_CALC   = 7'b0100000,
		ST_SEND   = 7'b1000000
	} state_t;

	state_t state_q;

	logic                  boot_en_q;
	logic [CNT_W-1:0]      count_q;
	logic [CAP_W-1:0]      running_end_q;
	logic [SIZE_W-1:0]     size0_q;          // block size of region 0, for boot protect

	// request decode
	logic [1:0]            cmd;
	logic [ADDR_W-1:0]     in_addr;
	logic [31:0]           in_desc;
	logic                  accept;

	// append path
	logic [31:0]           desc_q;
	logic [PROD_W-1:0]     prod_q;
	logic [SUM_W-1:0]      end_sum;
	logic [SUM_W-1:0]      end_cap;
	logic [CAP_W-1:0]      new_limit;
	logic [1:0]            app_status;
	logic                  append_wr;

	// lookup path
	logic [ADDR_W-1:0]     addr_q;
	logic                  bp_q;
	logic [REGION_IDX_W-1:0] hit_region_q;
	logic [SIZE_W-1:0]     hit_size_q;
	logic [CAP_W-1:0]      hit_base_q;
	logic [CAP_W-1:0]      hit_limit_q;
	logic [CMP_W-1:0]      offset;
	logic                  div_start;
	logic                  div_done;
	logic [QUO_W-1:0]      quo;
	logic [QUO_W-1:0]      idx_q;
	logic [ADDR_W-1:0]     prod2_q;
	logic [SW-1:0]         blk_start;
	logic [SW-1:0]         blk_end;
	logic [SW-1:0]         blk_end_clamped;

	// result holding and output register
	result_t               res_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                  m_tvalid_q;
	logic                  out_free;

	// cell chain
	token_t                tok [0:MAX_REGIONS];
	logic [CAP_W-1:0]      chain_base [0:MAX_REGIONS];
	logic [CAP_W-1:0]      chain_limit [0:MAX_REGIONS];

	assign cmd     = s_tuser;
	assign in_addr = s_tdata[ADDR_W-1:0];
	assign in_desc = s_tdata[IN_TDATA_W-1:ADDR_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// config register, no back-pressure
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_en_q <= 1'b1;
		end else if (cfg_valid) begin
			boot_en_q <= cfg_data;
		end
	end

	// chain entry: a lookup request starts at cell 0 on accept
	always_comb begin
		tok[0].active = accept && (cmd == CMD_LOOKUP);
		tok[0].hit    = 1'b0;
		tok[0].region = '0;
		tok[0].addr   = in_addr;
		tok[0].size   = '0;
	end
	assign chain_base[0]  = '0;
	assign chain_limit[0] = '0;

	// append writes cell number count_q in the ST_APPEND state
	assign append_wr = (state_q == ST_APPEND);

	for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
		fbg_cell #(
			.CAP_W (CAP_W),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tok_in    (tok[i]),
			.base_in   (chain_base[i]),
			.limit_in  (chain_limit[i]),
			.live      (CNT_W'(i) < count_q),
			.wr_en     (append_wr && (count_q == CNT_W'(i))),
			.wr_base   (running_end_q),
			.wr_limit  (new_limit),
			.wr_size   (desc_q[31:16]),
			.tok_out   (tok[i+1]),
			.base_out  (chain_base[i+1]),
			.limit_out (chain_limit[i+1])
		);
	end

	// region end: running end plus size * count, clamped at the address-space cap
	assign end_cap = SUM_W'(1) << ADDRESS_BITS;
	assign end_sum = SUM_W'(running_end_q) + SUM_W'(prod_q);
	always_comb begin
		new_limit  = end_sum[CAP_W-1:0];
		app_status = STATUS_OK;
		if (desc_q[31:16] == '0) begin
			app_status = STATUS_ZERO;
		end else if (end_sum > end_cap) begin
			new_limit  = end_cap[CAP_W-1:0];
			app_status = STATUS_SAT;
		end
	end

	// block index = (address - base) / 512 / size
	// base taken straight off the chain exit, the divider loads it on start
	assign offset = CMP_W'(addr_q) - CMP_W'(chain_base[MAX_REGIONS]);
	assign div_start = (state_q == ST_SCAN) && tok[MAX_REGIONS].active && tok[MAX_REGIONS].hit;

	fbg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (offset[ADDR_W-1:SIZE_SHIFT]),
		.divisor  (hit_size_q),
		.done     (div_done),
		.quotient (quo)
	);

	// block bounds, end clipped at the region limit
	assign blk_start = SW'(hit_base_q) + (SW'(prod2_q) << SIZE_SHIFT);
	assign blk_end   = blk_start + (SW'(hit_size_q) << SIZE_SHIFT);
	assign blk_end_clamped = (blk_end > SW'(hit_limit_q)) ? SW'(hit_limit_q) : blk_end;

	// sequencer and table control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			running_end_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd)
							CMD_CLEAR: begin
								count_q       <= '0;
								running_end_q <= '0;
								state_q       <= ST_SEND;
							end
							CMD_APPEND: begin
								state_q <= (count_q == CNT_W'(MAX_REGIONS)) ? ST_SEND : ST_APPEND;
							end
							CMD_LOOKUP: begin
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= ST_SEND;
							end
						endcase
					end
				end
				ST_APPEND: begin
					count_q       <= count_q + CNT_W'(1);
					running_end_q <= new_limit;
					state_q       <= ST_SEND;
				end
				ST_SCAN: begin
					if (tok[MAX_REGIONS].active) begin
						state_q <= tok[MAX_REGIONS].hit ? ST_DIV : ST_SEND;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers and the result being built
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				desc_q <= in_desc;
				addr_q <= in_addr;
				prod_q <= PROD_W'((BYTES_W'(in_desc[31:16]) << SIZE_SHIFT)
					* (PROD_W'(in_desc[15:0]) + PROD_W'(1)));
				bp_q   <= boot_en_q && ((count_q == '0)
					|| ({1'b0, in_addr} < (33'(size0_q) << SIZE_SHIFT)));
				if (accept && (cmd == CMD_APPEND) && (count_q == CNT_W'(MAX_REGIONS))) begin
					res_q <= '{status: STATUS_FULL, default: '0};
				end else begin
					res_q <= '0;
				end
			end
			ST_APPEND: begin
				res_q.status <= app_status;
				if (count_q == '0) begin
					size0_q <= desc_q[31:16];
				end
			end
			ST_SCAN: begin
				res_q.boot_protected <= bp_q;
				hit_region_q <= tok[MAX_REGIONS].region;
				hit_size_q   <= tok[MAX_REGIONS].size;
				hit_base_q   <= chain_base[MAX_REGIONS];
				hit_limit_q  <= chain_limit[MAX_REGIONS];
			end
			ST_DIV: begin
				idx_q <= quo;
			end
			ST_MUL: begin
				prod2_q <= ADDR_W'(idx_q) * ADDR_W'(hit_size_q);
			end
			ST_CALC: begin
				res_q.found        <= 1'b1;
				res_q.region_index <= hit_region_q[4:0];
				res_q.block_index  <= idx_q;
				res_q.block_start  <= blk_start[31:0];
				res_q.block_end    <= blk_end_clamped[32:0];
			end
			ST_SEND: begin
				if (out_free) begin
					m_tdata_q <= OUT_TDATA_W'(res_q);
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_SEND) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// table never grows past its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_REGIONS))
		else $error("region count above table depth");

	// running end never passes the address-space cap
	a_end_cap: assert property (@(posedge clk) disable iff (!arst_n)
		running_end_q <= (CAP_W'(1) << ADDRESS_BITS))
		else $error("running end above cap");

	// a request leaves the chain only while the sequencer waits for it
	a_chain_exit: assert property (@(posedge clk) disable iff (!arst_n)
		tok[MAX_REGIONS].active |-> (state_q == ST_SCAN))
		else $error("chain exit outside scan");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider done outside divide");

	// a clear empties the table at once
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == CMD_CLEAR)) |=> ((count_q == '0) && (running_end_q == '0)))
		else $error("clear did not empty table");

endmodule

// ----- tb/flash_erase_block_geometry_tb.sv -----
`timescale 1ns / 1ps

module flash_erase_block_geometry_tb;
	import fbg_pkg::*;

	localparam int MAX_REGIONS    = 32;
	localparam int LOOKUP_LATENCY = MAX_REGIONS + 21;  // slowest request, chain walk plus divide
	localparam int HOLD_CYCLES    = 400;               // long output stall in the pressure test
	localparam int LIMIT_CYCLES   = 800000;
	localparam int PHASE_REQUESTS = 220;
	localparam logic [63:0] END_CAP = 64'd1 << 32;

	// the package has no name for the spare command code
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_SPARSE,
		RDY_PERIODIC
	} ready_mode_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_data  = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // address[31:0], descriptor[63:32]
	logic [1:0]             s_tuser   = '0;   // command[1:0]
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;          // found, region_index, block_index, block_start,
	                                          // block_end, boot_protected, status, zero pad

	flash_erase_block_geometry #(
		.MAX_REGIONS (MAX_REGIONS),
		.ADDRESS_BITS(32)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow copy of the region table, updated as each request is accepted
	logic [32:0] geo_base        [MAX_REGIONS];
	logic [32:0] geo_limit       [MAX_REGIONS];
	logic [25:0] geo_block_bytes [MAX_REGIONS];
	logic [5:0]  geo_count  = '0;
	logic [32:0] geo_end    = '0;
	logic        protect_en = 1'b1;  // boot_protect_enable comes out of reset set

	result_t expected_results[$];

	int cycle_count   = 0;
	int mismatches    = 0;
	int requests_sent = 0;
	int burst_left    = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int pattern_left  = 0;
	ready_mode_t ready_mode = RDY_ALWAYS;

	// coverage tallies for the closing summary
	int lookups_seen   = 0;
	int hits_seen      = 0;
	int protected_seen = 0;
	int cfg_writes     = 0;
	int append_status_seen[4] = '{0, 0, 0, 0};

	// expected result of one request; advances the shadow table the way the block does
	function automatic result_t predict_geometry(input logic [1:0] cmd,
			input logic [31:0] addr, input logic [31:0] desc);
		result_t     r;
		logic [63:0] bytes, span, new_end, a, base, idx, start, stop;
		r = '0;
		a = 64'(addr);
		case (cmd)
			CMD_CLEAR: begin
				geo_count = '0;
				geo_end   = '0;
			end
			CMD_APPEND: begin
				if (geo_count >= MAX_REGIONS) begin
					r.status = STATUS_FULL;
				end else begin
					bytes   = 64'(desc[31:16]) << 9;
					span    = bytes * (64'(desc[15:0]) + 64'd1);
					new_end = 64'(geo_end) + span;
					geo_base[geo_count]        = geo_end;
					geo_block_bytes[geo_count] = bytes[25:0];
					if (bytes == 0) begin
						r.status = STATUS_ZERO;
					end else if (new_end > END_CAP) begin
						// region kept, end pinned to the top of the address space
						new_end  = END_CAP;
						r.status = STATUS_SAT;
					end
					geo_limit[geo_count] = new_end[32:0];
					geo_end              = new_end[32:0];
					geo_count            = geo_count + 6'd1;
				end
			end
			CMD_LOOKUP: begin
				// empty table protects everything, otherwise only region 0's first block
				if (protect_en && (geo_count == 0 || (a >= 64'(geo_base[0]) &&
						a < 64'(geo_base[0]) + 64'(geo_block_bytes[0]))))
					r.boot_protected = 1'b1;
				for (int i = 0; i < geo_count; i++) begin
					base  = 64'(geo_base[i]);
					bytes = 64'(geo_block_bytes[i]);
					if (!r.found && bytes != 0 && a >= base && a < 64'(geo_limit[i])) begin
						idx   = (a - base) / bytes;
						start = base + idx * bytes;
						stop  = start + bytes;
						// last block of a saturated region is cut at the limit
						if (stop > 64'(geo_limit[i]))
							stop = 64'(geo_limit[i]);
						r.found        = 1'b1;
						r.region_index = i[4:0];
						r.block_index  = idx[15:0];
						r.block_start  = start[31:0];
						r.block_end    = stop[32:0];
					end
				end
			end
			default: ;  // spare command leaves the table alone and reports all zeros
		endcase
		return r;
	endfunction

	// sender: bursts of back-to-back requests with random gaps between them
	task automatic send_request(input logic [1:0] cmd, input logic [31:0] addr,
			input logic [31:0] desc);
		result_t r;
		int      gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {desc, addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		// request taken at this edge
		r = predict_geometry(cmd, addr, desc);
		expected_results.push_back(r);
		requests_sent++;
		burst_left--;
		if (cmd == CMD_LOOKUP) begin
			lookups_seen++;
			if (r.found)
				hits_seen++;
			if (r.boot_protected)
				protected_seen++;
		end else if (cmd == CMD_APPEND) begin
			append_status_seen[r.status]++;
		end
	endtask

	// stop offering and wait until every result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// boot_protect_enable is only written with the block idle
	task automatic write_protect_enable(input logic value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid  <= 1'b0;
		protect_en = value;
		cfg_writes++;
	endtask

	// mostly small regions, with some empty, huge and saturating ones
	function automatic logic [31:0] pick_descriptor();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return {16'd0, 16'($urandom)};
		if (r <= 2)
			return $urandom;
		if (r <= 4)
			return {16'($urandom_range(1, 65535)), 16'($urandom_range(0, 3))};
		return {16'($urandom_range(1, 64)), 16'($urandom_range(0, 31))};
	endfunction

	// addresses aimed at stored regions and their edges, plus fully random ones
	function automatic logic [31:0] pick_address();
		int          r;
		int          k;
		logic [63:0] lo, hi, off;
		r = $urandom_range(0, 9);
		if (geo_count == 0 || r == 0)
			return $urandom;
		k  = $urandom_range(0, int'(geo_count) - 1);
		lo = 64'(geo_base[k]);
		hi = 64'(geo_limit[k]);
		case (r)
			1: return lo[31:0];
			2: return 32'(hi - 64'd1);
			3: return hi[31:0];
			4: return 32'(lo + 64'(geo_block_bytes[k]) - 64'd1);
			default: begin
				if (hi <= lo)
					return lo[31:0];
				off = {$urandom, $urandom} % (hi - lo);
				return 32'(lo + off);
			end
		endcase
	endfunction

	// clear, build a table, then query it with some appends and noise mixed in
	task automatic run_geometry_sequence(input int regions);
		int queries;
		int r;
		send_request(CMD_CLEAR, $urandom, $urandom);
		repeat (regions) send_request(CMD_APPEND, $urandom, pick_descriptor());
		queries = $urandom_range(4, 14);
		repeat (queries) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				send_request(CMD_APPEND, $urandom, pick_descriptor());
			else if (r == 1)
				send_request(CMD_UNUSED, $urandom, $urandom);
			else if (r == 2)
				send_request(2'($urandom_range(0, 3)), $urandom, $urandom);
			else
				send_request(CMD_LOOKUP, pick_address(), $urandom);
		end
	endtask

	// empty table: nothing found, every address protected
	task automatic test_empty_table();
		send_request(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
		send_request(CMD_LOOKUP, 32'hffff_ffff, 32'hffff_ffff);
	endtask

	// zero-size region, normal region, saturation and append past the cap
	task automatic test_append_status();
		send_request(CMD_APPEND, 32'h0, 32'h0000_0000);
		send_request(CMD_LOOKUP, 32'h0, 32'h0);
		send_request(CMD_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
		send_request(CMD_APPEND, 32'h0, 32'h0001_0003);   // four 512-byte blocks
		send_request(CMD_APPEND, 32'h0, 32'hffff_ffff);   // far past 4 GiB
		send_request(CMD_APPEND, 32'h0, 32'h0001_0000);   // starts at the cap
	endtask

	// block edges in region 0 and the saturated last block of region 1
	task automatic test_lookup_bounds();
		send_request(CMD_LOOKUP, 32'd0, 32'h0);
		send_request(CMD_LOOKUP, 32'd511, 32'h0);
		send_request(CMD_LOOKUP, 32'd512, 32'h0);
		send_request(CMD_LOOKUP, 32'd2047, 32'h0);
		send_request(CMD_LOOKUP, 32'd2048, 32'h0);
		send_request(CMD_LOOKUP, 32'hffff_ffff, 32'h0);
	endtask

	// spare command must not disturb the table
	task automatic test_unused_command();
		send_request(CMD_UNUSED, $urandom, $urandom);
		send_request(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
		send_request(CMD_LOOKUP, 32'd2048, 32'h0);
	endtask

	// protection off, then back on with an empty table
	task automatic test_boot_protect_off();
		write_protect_enable(1'b0);
		send_request(CMD_LOOKUP, 32'd0, 32'h0);
		send_request(CMD_CLEAR, 32'h0, 32'h0);
		send_request(CMD_LOOKUP, 32'd0, 32'h0);
		write_protect_enable(1'b1);
		send_request(CMD_LOOKUP, 32'd5, 32'h0);
	endtask

	// random tables in several protect settings; first one overfills the table
	task automatic test_random_geometry();
		int phase_start;
		int r;
		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 0)
				write_protect_enable(1'b0);
			else if (phase == 1)
				write_protect_enable(1'b1);
			else
				write_protect_enable(1'($urandom_range(0, 1)));
			phase_start = requests_sent;
			if (phase == 0)
				run_geometry_sequence(MAX_REGIONS + 2);
			while (requests_sent - phase_start < PHASE_REQUESTS) begin
				r = $urandom_range(0, 7);
				run_geometry_sequence(r == 0 ? $urandom_range(24, MAX_REGIONS + 2)
				                             : $urandom_range(0, 6));
			end
		end
	endtask

	// receiver holds off while the sender keeps offering lookups
	task automatic test_output_stall();
		drain_results();
		send_request(CMD_CLEAR, $urandom, $urandom);
		send_request(CMD_APPEND, $urandom, 32'h0004_000f);
		send_request(CMD_APPEND, $urandom, pick_descriptor());
		hold_requests <= hold_requests + 1;
		burst_left = 1000;
		repeat (12) send_request(CMD_LOOKUP, pick_address(), $urandom);
		burst_left = 0;
		drain_results();
	endtask

	// receiver: stall patterns of varying length, or a long hold when asked
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (pattern_left == 0) begin
				ready_mode   = ready_mode_t'($urandom_range(0, 3));
				pattern_left = $urandom_range(20, 200);
			end
			pattern_left--;
			case (ready_mode)
				RDY_ALWAYS: m_tready <= 1'b1;
				RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:    m_tready <= (pattern_left % 16) < 4;
			endcase
		end
	end

	task automatic check_field(input string name, input logic [32:0] exp_v,
			input logic [32:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
		end
	endtask

	// result checker: each result against the oldest outstanding request
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[RES_W-1:0]);
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no request outstanding, got %h",
						$realtime, m_tdata);
			end else begin
				want = expected_results.pop_front();
				check_field("found", 33'(want.found), 33'(got.found));
				check_field("region_index", 33'(want.region_index), 33'(got.region_index));
				check_field("block_index", 33'(want.block_index), 33'(got.block_index));
				check_field("block_start", 33'(want.block_start), 33'(got.block_start));
				check_field("block_end", want.block_end, got.block_end);
				check_field("boot_protected", 33'(want.boot_protected),
					33'(got.boot_protected));
				check_field("status", 33'(want.status), 33'(got.status));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("[flash_erase_block_geometry] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_append_status();
		test_lookup_bounds();
		test_unused_command();
		test_boot_protect_off();
		test_random_geometry();
		test_output_stall();

		drain_results();
		repeat (LOOKUP_LATENCY + 8) @(posedge clk);

		$display("ran %0d requests: %0d lookups, %0d hits, %0d boot-protected, %0d cfg writes",
			requests_sent, lookups_seen, hits_seen, protected_seen, cfg_writes);
		$display("appends by status: ok %0d, full %0d, zero size %0d, saturated %0d",
			append_status_seen[STATUS_OK], append_status_seen[STATUS_FULL],
			append_status_seen[STATUS_ZERO], append_status_seen[STATUS_SAT]);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("[flash_erase_block_geometry] OK");
		else
			$display("[flash_erase_block_geometry] ERROR");
		$finish;
	end

endmodule
